[rtl/core/g726_codeword_bit_order_convert_unit_assert.svh]
// Assertion macros shared by the checker of the G.726 bit order converter.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef G726_CODEWORD_BIT_ORDER_CONVERT_UNIT_ASSERT_SVH
`define G726_CODEWORD_BIT_ORDER_CONVERT_UNIT_ASSERT_SVH

// Implication property checked at every rising edge outside reset.
`define G726CBO_ASSERT_IMPL(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// Next-cycle implication property checked outside reset.
`define G726CBO_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

[rtl/core/g726cbo_pkg.sv]
// Types, codes and bit permutation functions of the G.726 bit order converter.
// No dependencies; every other file but the assertion header imports it.
package g726cbo_pkg;

	localparam int GROUP_MAX = 5;
	localparam int HOLD_MAX  = 4;

	// Configuration register indexes.
	localparam logic [1:0] CFG_ENABLE    = 2'd0;
	localparam logic [1:0] CFG_RATE_MODE = 2'd1;
	localparam logic [1:0] CFG_NET_DIR   = 2'd2;

	// Rate mode codes.
	localparam logic [1:0] RATE_16K = 2'd0;
	localparam logic [1:0] RATE_24K = 2'd1;
	localparam logic [1:0] RATE_32K = 2'd2;
	localparam logic [1:0] RATE_40K = 2'd3;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] cnt_t;
	typedef logic [1:0] cfg_idx_t;
	typedef logic [1:0] cfg_data_t;
	typedef logic [GROUP_MAX-1:0][7:0] group_t;

	typedef struct packed {
		logic       enable;
		logic [1:0] rate_mode;
		logic       net_dir;
	} cfg_t;

	// One finished group waiting for the output side.
	typedef struct packed {
		group_t bytes;
		cnt_t   count;
		logic   last;
	} entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	function automatic byte_t swap_pairs(input byte_t a);
		return {a[1:0], a[3:2], a[5:4], a[7:6]};
	endfunction

	function automatic byte_t swap_nibbles(input byte_t a);
		return {a[3:0], a[7:4]};
	endfunction

	function automatic group_t perm3(input byte_t a, input byte_t b, input byte_t c,
			input logic net);
		group_t y;
		y = '0;
		if (!net) begin
			y[0] = {a[2:0], a[5:3], b[0], a[7]};
			y[1] = {a[6], b[3:1], b[6:4], c[1]};
			y[2] = {c[0], b[7], c[4:2], c[7:5]};
		end else begin
			y[0] = {a[0], b[7], a[4:2], a[7:5]};
			y[1] = {c[6], b[3:1], b[6:4], a[1]};
			y[2] = {c[2:0], c[5:3], b[0], c[7]};
		end
		return y;
	endfunction

	function automatic group_t perm5(input byte_t a, input byte_t b, input byte_t c,
			input byte_t d, input byte_t e, input logic net);
		group_t y;
		if (!net) begin
			y[0] = {a[4:0], b[1:0], a[7]};
			y[1] = {a[6:5], b[6:2], c[3]};
			y[2] = {c[2:0], b[7], d[0], c[7:5]};
			y[3] = {c[4], d[5:1], e[2:1]};
			y[4] = {e[0], d[7:6], e[7:3]};
		end else begin
			y[0] = {a[0], b[7:6], a[7:3]};
			y[1] = {c[4], b[5:1], a[2:1]};
			y[2] = {c[2:0], d[7], b[0], c[7:5]};
			y[3] = {e[6:5], d[6:2], c[3]};
			y[4] = {e[4:0], d[1:0], e[7]};
		end
		return y;
	endfunction

endpackage

[rtl/core/g726cbo_if.sv]
// Handshake channels of the G.726 bit order converter: input bytes,
// output bytes and configuration writes. Depends on g726cbo_pkg.
interface g726cbo_in_if import g726cbo_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  is_last;

	modport source (output valid, output data_byte, output is_last, input ready);
	modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

interface g726cbo_out_if import g726cbo_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

interface g726cbo_cfg_if import g726cbo_pkg::*; ();
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/g726cbo_front.sv]
// Front end: accepts input bytes, collects groups and repacks finished ones.
// Depends on g726cbo_pkg and g726cbo_in_if.
module g726cbo_front import g726cbo_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	g726cbo_in_if.sink din,
	input  logic   q_full,
	output logic   push,
	output entry_t push_entry
);

	byte_t  grp_q [HOLD_MAX];
	cnt_t   cnt_q;

	cnt_t   held;
	cnt_t   n;
	cnt_t   size;
	group_t gbytes;
	group_t conv;
	logic   convert;
	logic   hold;
	logic   fire;

	assign din.ready = !q_full;
	assign fire      = din.valid && din.ready;

	always_comb begin
		held = cnt_q;
		n    = held + 3'd1;
		size = 3'd1;
		if (cfg.enable) begin
			unique case (cfg.rate_mode)
				RATE_24K: size = 3'd3;
				RATE_40K: size = 3'd5;
				default:  size = 3'd1;
			endcase
		end

		// Held bytes first, the new byte right after them.
		for (int i = 0; i < HOLD_MAX; i++) begin
			gbytes[i] = (3'(i) < held) ? grp_q[i] : din.data_byte;
		end
		gbytes[GROUP_MAX-1] = din.data_byte;

		conv = gbytes;
		unique case (cfg.rate_mode)
			RATE_16K: conv[0] = swap_pairs(gbytes[0]);
			RATE_32K: conv[0] = swap_nibbles(gbytes[0]);
			RATE_24K: conv = perm3(gbytes[0], gbytes[1], gbytes[2], cfg.net_dir);
			RATE_40K: conv = perm5(gbytes[0], gbytes[1], gbytes[2], gbytes[3], gbytes[4],
				cfg.net_dir);
		endcase

		convert = cfg.enable && (n == size);
		hold    = !convert && (n < size) && !din.is_last;

		push             = fire && !hold;
		push_entry.bytes = convert ? conv : gbytes;
		push_entry.count = n;
		push_entry.last  = din.is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (fire) begin
			cnt_q <= hold ? n : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && hold) begin
			grp_q[held[1:0]] <= din.data_byte;
		end
	end

endmodule

[rtl/core/g726cbo_queue.sv]
// Short queue of finished groups between the front and back ends.
// Depends on g726cbo_pkg.
module g726cbo_queue import g726cbo_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  entry_t    push_entry,
	input  logic      pop,
	output entry_t    head,
	output q_status_t status
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	logic do_push;
	logic do_pop;

	assign status.empty = (cnt_q == '0);
	assign status.full  = (cnt_q == CNT_W'(DEPTH));
	assign head         = mem_q[rd_ptr_q];
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

[rtl/core/g726cbo_back.sv]
// Back end: walks queued groups to the output register, a byte per free cycle.
// Depends on g726cbo_pkg and g726cbo_out_if.
module g726cbo_back import g726cbo_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  entry_t    head,
	input  q_status_t status,
	output logic      pop,
	g726cbo_out_if.source dout
);

	cnt_t  idx_q;
	logic  valid_q;
	byte_t byte_q;
	logic  last_q;

	cnt_t  last_idx;
	logic  at_end;
	logic  load;

	assign last_idx = head.count - 3'd1;
	assign at_end   = (idx_q == last_idx);
	assign load     = !status.empty && (!valid_q || dout.ready);
	assign pop      = load && at_end;

	assign dout.valid    = valid_q;
	assign dout.out_byte = byte_q;
	assign dout.out_last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_end ? '0 : idx_q + 3'd1;
			end else if (dout.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head.bytes[idx_q];
			last_q <= head.last && at_end;
		end
	end

endmodule

[rtl/core/g726_codeword_bit_order_convert_unit.sv]
// Top level of the G.726 code word bit order converter.
// Depends on g726cbo_pkg, the channel interfaces, and the front, queue and back modules.

// The unit repacks a byte stream of packed G.726 code words between host bit order
// (first code word in the most significant bits) and network bit order (first code
// word in the least significant bits). Writing register 0 (enable) to one turns the
// repacking on; with it at zero every byte passes through unchanged. Register 1 selects
// the rate: 16k and 32k streams have their 2-bit or 4-bit words reversed inside each
// byte, while 24k and 40k streams are permuted over groups of 3 and 5 bytes. Register 2
// picks the direction of those group permutations. Configuration requests are always
// taken at once, but they should only be issued while the unit is idle. The front end
// accepts one input request per clock cycle while the queue is not full, and holds the
// bytes of an open group; once the group is complete, or a byte flagged is_last ends
// a partial group, or a rate change or disabling makes the held bytes overrun the new
// group size, the group is pushed into a queue of QUEUE_DEPTH entries, and a partial
// group is sent unchanged. The back end drains the queue one byte per cycle, unless
// the output stalls, through an output register, so a group of 3 or 5 bytes leaves as
// a burst of 3 or 5 output requests, and only the byte that closes a buffer carries
// out_last. Each group is first written into the queue and then loaded from the queue
// head into the output register, one byte at a time. The sustained rate is one byte
// per cycle in both directions; the input stalls only when QUEUE_DEPTH finished
// groups wait because the output side is stalled.
module g726_codeword_bit_order_convert_unit import g726cbo_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	g726cbo_cfg_if.sink   cfg,
	g726cbo_in_if.sink    din,
	g726cbo_out_if.source dout
);

	cfg_t      cfg_q;
	logic      push;
	logic      pop;
	entry_t    push_entry;
	entry_t    head;
	q_status_t q_status;

	// Register writes never stall; an index outside the register list is ignored.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_ENABLE:    cfg_q.enable    <= cfg.data[0];
				CFG_RATE_MODE: cfg_q.rate_mode <= cfg.data;
				CFG_NET_DIR:   cfg_q.net_dir   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	g726cbo_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.din        (din),
		.q_full     (q_status.full),
		.push       (push),
		.push_entry (push_entry)
	);

	g726cbo_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	g726cbo_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.status (q_status),
		.pop    (pop),
		.dout   (dout)
	);

endmodule

[rtl/core/g726cbo_checker.sv]
// Port-level checker of the G.726 bit order converter and its bind statement.
// Depends on g726cbo_pkg and g726_codeword_bit_order_convert_unit_assert.svh.
`include "g726_codeword_bit_order_convert_unit_assert.svh"

module g726cbo_checker import g726cbo_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  cfg_valid,
	input logic  cfg_ready,
	input logic  din_ready,
	input logic  dout_valid,
	input logic  dout_ready,
	input byte_t out_byte,
	input logic  out_last
);

	// A stalled output request keeps its byte and end mark.
	`G726CBO_ASSERT_NEXT(a_out_hold, dout_valid && !dout_ready, dout_valid && $stable(out_byte) && $stable(out_last), "output request changed while stalled")

	// Configuration writes are never refused.
	`G726CBO_ASSERT_IMPL(a_cfg_ready, cfg_valid, cfg_ready, "configuration request refused")

	// The input only stalls while the output side holds a byte.
	`G726CBO_ASSERT_IMPL(a_stall_cause, !din_ready, dout_valid, "input stalled with empty output")

endmodule

bind g726_codeword_bit_order_convert_unit g726cbo_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cfg_valid  (cfg.valid),
	.cfg_ready  (cfg.ready),
	.din_ready  (din.ready),
	.dout_valid (dout.valid),
	.dout_ready (dout.ready),
	.out_byte   (dout.out_byte),
	.out_last   (dout.out_last)
);

[tb/sv/g726_codeword_bit_order_convert_unit_tb.sv]
// Self-checking testbench of the G.726 code word bit order converter: directed table,
// then random phases of byte buffers, each checked against an in-bench repacking predictor.
// Depends on g726cbo_pkg, the channel interfaces and g726_codeword_bit_order_convert_unit.
module g726_codeword_bit_order_convert_unit_tb import g726cbo_pkg::*; ();

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 12;
	// The first output byte passes through the queue and the output register; this wait
	// leaves ample room for a held group to settle before the registers change.
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 64;
	localparam int IDLE_LIMIT    = 2000;
	localparam int RANDOM_ITEMS  = 400;

	// One expected output request.
	typedef struct packed {
		byte_t data;
		logic  last;
	} out_req_t;

	typedef enum logic {
		ROW_BYTE,
		ROW_WRITE
	} row_kind_e;

	// One row of the directed table: either an input byte or a register write.
	// Rows whose output is obvious carry it typed in; the rest use the predictor.
	typedef struct packed {
		row_kind_e kind;
		cfg_idx_t  reg_idx;
		cfg_data_t reg_val;
		byte_t     data;
		logic      last;
		logic      typed;
		byte_t     want_byte;
		logic      want_last;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;

	g726cbo_cfg_if cfg_ch ();
	g726cbo_in_if  in_ch ();
	g726cbo_out_if out_ch ();

	g726_codeword_bit_order_convert_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.din    (in_ch),
		.dout   (out_ch)
	);

	always #CLK_HALF clk = ~clk;

	// Predictor copy of the configuration registers.
	logic       repack_on;
	logic [1:0] rate_sel;
	logic       net_order;

	// Predictor copy of the open group: bytes held until the group is complete.
	byte_t open_group [HOLD_MAX];
	int    open_count;

	// Output requests predicted but not yet seen, oldest first.
	out_req_t pending_bytes [$];
	row_t     directed_rows [$];

	int errors        = 0;
	int bytes_sent    = 0;
	int bytes_checked = 0;
	int reg_writes    = 0;
	int idle_cycles   = 0;
	int burst_left    = 0;

	// steady_send removes the sender's gaps; long_hold_req asks the receiver for a
	// long stall, which it times itself and then clears.
	bit steady_send   = 1'b0;
	bit long_hold_req = 1'b0;

	// 16k: reverse the four 2-bit code words inside a byte.
	function automatic byte_t reverse_pairs(byte_t a);
		return ((a & 8'h03) << 6) | ((a & 8'h0C) << 2) | ((a & 8'h30) >> 2) |
			((a & 8'hC0) >> 6);
	endfunction

	// 32k: swap the two 4-bit code words of a byte.
	function automatic byte_t reverse_nibbles(byte_t a);
		return ((a & 8'h0F) << 4) | ((a & 8'hF0) >> 4);
	endfunction

	// 24k: eight 3-bit code words spread over three bytes.
	function automatic group_t permute24(group_t x, logic net);
		group_t y;
		byte_t  a, b, c;
		a = x[0];
		b = x[1];
		c = x[2];
		y = '0;
		if (!net) begin
			y[0] = ((a & 8'h07) << 5) | ((a & 8'h38) >> 1) | ((b & 8'h01) << 1) |
				((a & 8'h80) >> 7);
			y[1] = ((a & 8'h40) << 1) | ((b & 8'h0E) << 3) | ((b & 8'h70) >> 3) |
				((c & 8'h02) >> 1);
			y[2] = ((c & 8'h01) << 7) | ((b & 8'h80) >> 1) | ((c & 8'h1C) << 1) |
				((c & 8'hE0) >> 5);
		end else begin
			y[0] = ((a & 8'hE0) >> 5) | ((a & 8'h1C) << 1) | ((b & 8'h80) >> 1) |
				((a & 8'h01) << 7);
			y[1] = ((a & 8'h02) >> 1) | ((b & 8'h70) >> 3) | ((b & 8'h0E) << 3) |
				((c & 8'h40) << 1);
			y[2] = ((c & 8'h80) >> 7) | ((b & 8'h01) << 1) | ((c & 8'h38) >> 1) |
				((c & 8'h07) << 5);
		end
		return y;
	endfunction

	// 40k: eight 5-bit code words spread over five bytes.
	function automatic group_t permute40(group_t x, logic net);
		group_t y;
		byte_t  a, b, c, d, e;
		a = x[0];
		b = x[1];
		c = x[2];
		d = x[3];
		e = x[4];
		if (!net) begin
			y[0] = ((a & 8'h1F) << 3) | ((b & 8'h03) << 1) | ((a & 8'h80) >> 7);
			y[1] = ((a & 8'h60) << 1) | ((b & 8'h7C) >> 1) | ((c & 8'h08) >> 3);
			y[2] = ((c & 8'h07) << 5) | ((b & 8'h80) >> 3) | ((d & 8'h01) << 3) |
				((c & 8'hE0) >> 5);
			y[3] = ((c & 8'h10) << 3) | ((d & 8'h3E) << 1) | ((e & 8'h06) >> 1);
			y[4] = ((e & 8'h01) << 7) | ((d & 8'hC0) >> 1) | ((e & 8'hF8) >> 3);
		end else begin
			y[0] = ((a & 8'hF8) >> 3) | ((b & 8'hC0) >> 1) | ((a & 8'h01) << 7);
			y[1] = ((a & 8'h06) >> 1) | ((b & 8'h3E) << 1) | ((c & 8'h10) << 3);
			y[2] = ((c & 8'hE0) >> 5) | ((b & 8'h01) << 3) | ((d & 8'h80) >> 3) |
				((c & 8'h07) << 5);
			y[3] = ((c & 8'h08) >> 3) | ((d & 8'h7C) >> 1) | ((e & 8'h60) << 1);
			y[4] = ((e & 8'h80) >> 7) | ((d & 8'h03) << 1) | ((e & 8'h1F) << 3);
		end
		return y;
	endfunction

	// Works out what one accepted input byte emits. A byte that only extends an open
	// group emits nothing (count 0). With repacking on, a group that reaches the size of
	// the current rate is converted; anything else that must leave (a buffer end on a
	// partial group, the unit disabled with bytes held, or held bytes overrunning a
	// smaller group after a rate change) leaves unchanged, in order.
	task automatic predict_repack(input byte_t d, input logic l, output int count,
			output group_t y);
		group_t x;
		int     size;
		x = '0;
		y = '0;
		for (int i = 0; i < open_count; i++)
			x[i] = open_group[i];
		x[open_count] = d;
		count = open_count + 1;
		if (!repack_on)
			size = 1;
		else if (rate_sel == RATE_24K)
			size = 3;
		else if (rate_sel == RATE_40K)
			size = 5;
		else
			size = 1;
		if (repack_on && count == size) begin
			case (rate_sel)
				RATE_16K: y[0] = reverse_pairs(x[0]);
				RATE_32K: y[0] = reverse_nibbles(x[0]);
				RATE_24K: y = permute24(x, net_order);
				default:  y = permute40(x, net_order);
			endcase
		end else if (count < size && !l) begin
			open_group[open_count] = d;
			open_count = count;
			count = 0;
		end else begin
			y = x;
		end
		if (count != 0)
			open_count = 0;
	endtask

	function automatic row_t byte_row(byte_t d, logic l);
		row_t r;
		r = '0;
		r.kind = ROW_BYTE;
		r.data = d;
		r.last = l;
		return r;
	endfunction

	function automatic row_t typed_row(byte_t d, logic l, byte_t wb, logic wl);
		row_t r;
		r = byte_row(d, l);
		r.typed = 1'b1;
		r.want_byte = wb;
		r.want_last = wl;
		return r;
	endfunction

	function automatic row_t write_row(cfg_idx_t idx, cfg_data_t val);
		row_t r;
		r = '0;
		r.kind = ROW_WRITE;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	// Offers one input request and returns just after the edge that accepted it.
	// The sender runs in bursts of random length with random gaps, none with steady_send.
	// Ready is looked at on the falling edge, where every signal is settled, so the
	// request is known to go through at the next rising edge; the predicted output
	// is queued right then.
	task automatic send_byte(input row_t r);
		int       gap, count;
		group_t   y;
		out_req_t e;
		if (burst_left == 0) begin
			gap = steady_send ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= r.data;
		in_ch.is_last <= r.last;
		do @(negedge clk); while (!in_ch.ready);
		predict_repack(r.data, r.last, count, y);
		if (r.typed && count == 1) begin
			e.data = r.want_byte;
			e.last = r.want_last;
			pending_bytes.push_back(e);
		end else begin
			for (int i = 0; i < count; i++) begin
				e.data = y[i];
				e.last = r.last && (i == count - 1);
				pending_bytes.push_back(e);
			end
		end
		bytes_sent++;
		@(posedge clk);
	endtask

	// Stops offering input, waits for every predicted output request, then lets the
	// unit settle. Bytes of an open group stay held inside the unit meanwhile.
	task automatic drain_outputs();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_bytes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register writes only happen with the unit idle, so each one drains first.
	task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
		drain_outputs();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(negedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_ENABLE:    repack_on = val[0];
			CFG_RATE_MODE: rate_sel = val;
			CFG_NET_DIR:   net_order = val[0];
			default:       ;
		endcase
		reg_writes++;
		@(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Output side: stalls on a pattern of its own, picked anew after each random span
	// (always ready, coin toss, mostly ready, ready on every fourth tick), and on request
	// holds off for a long stretch so the queue fills and the input side backs up.
	initial begin : receiver
		int mode, span, tick;
		mode = 0;
		span = 0;
		tick = 0;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_req = 1'b0;
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 3);
					span = $urandom_range(16, 96);
				end
				case (mode)
					0:       out_ch.ready <= 1'b1;
					1:       out_ch.ready <= 1'($urandom_range(0, 1));
					2:       out_ch.ready <= ($urandom_range(0, 7) != 0);
					default: out_ch.ready <= (tick % 4 == 0);
				endcase
				tick++;
				span--;
				@(posedge clk);
			end
		end
	end

	// Every output request taken is compared, field by field, with the oldest one
	// predicted.
	always @(negedge clk) begin : output_check
		out_req_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_bytes.size() == 0) begin
				$display("%0t: output byte %02h last %0b arrived with none expected",
					$time, out_ch.out_byte, out_ch.out_last);
				errors++;
			end else begin
				want = pending_bytes.pop_front();
				if (out_ch.out_byte !== want.data) begin
					$display("%0t: out_byte expected %02h, got %02h",
						$time, want.data, out_ch.out_byte);
					errors++;
				end
				if (out_ch.out_last !== want.last) begin
					$display("%0t: out_last expected %0b, got %0b",
						$time, want.last, out_ch.out_last);
					errors++;
				end
				bytes_checked++;
			end
		end
	end

	// Ends the run if no request moves on any channel for too long. The longest quiet
	// stretch of a correct run is the receiver's long hold-off, far below this limit.
	initial begin : watchdog
		wait (arst_n === 1'b1);
		while (idle_cycles < IDLE_LIMIT) begin
			@(negedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
		$display("g726_codeword_bit_order_convert_unit_tb: FAIL");
		$finish;
	end

	initial begin : stimulus
		int         p, target, size, len, pick, first;
		cfg_data_t  rate;
		logic       on, net;

		arst_n <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_ENABLE;
		cfg_ch.data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.data_byte <= '0;
		in_ch.is_last <= 1'b0;
		repack_on = 1'b0;
		rate_sel = RATE_16K;
		net_order = 1'b0;
		open_count = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset the unit is disabled, so bytes pass straight through.
		directed_rows.push_back(typed_row(8'hA5, 1'b0, 8'hA5, 1'b0));
		directed_rows.push_back(typed_row(8'h3C, 1'b1, 8'h3C, 1'b1));
		// 16k: all ones and all zeros map onto themselves; 0x1B reverses to 0xE4.
		directed_rows.push_back(write_row(CFG_ENABLE, 2'd1));
		directed_rows.push_back(typed_row(8'hFF, 1'b0, 8'hFF, 1'b0));
		directed_rows.push_back(typed_row(8'h00, 1'b0, 8'h00, 1'b0));
		directed_rows.push_back(typed_row(8'h1B, 1'b1, 8'hE4, 1'b1));
		// 32k: nibbles swap.
		directed_rows.push_back(write_row(CFG_RATE_MODE, RATE_32K));
		directed_rows.push_back(typed_row(8'hF0, 1'b0, 8'h0F, 1'b0));
		directed_rows.push_back(typed_row(8'h12, 1'b1, 8'h21, 1'b1));
		// 24k to host order: one whole group, then a buffer ending on a partial group.
		directed_rows.push_back(write_row(CFG_RATE_MODE, RATE_24K));
		directed_rows.push_back(byte_row(8'hFF, 1'b0));
		directed_rows.push_back(byte_row(8'h00, 1'b0));
		directed_rows.push_back(byte_row(8'hAA, 1'b1));
		directed_rows.push_back(byte_row(8'h81, 1'b0));
		directed_rows.push_back(byte_row(8'h7E, 1'b1));
		// 24k and then 40k to network order.
		directed_rows.push_back(write_row(CFG_NET_DIR, 2'd1));
		directed_rows.push_back(byte_row(8'h01, 1'b0));
		directed_rows.push_back(byte_row(8'h80, 1'b0));
		directed_rows.push_back(byte_row(8'hFE, 1'b0));
		directed_rows.push_back(write_row(CFG_RATE_MODE, RATE_40K));
		directed_rows.push_back(byte_row(8'hFF, 1'b0));
		directed_rows.push_back(byte_row(8'h00, 1'b0));
		directed_rows.push_back(byte_row(8'hFF, 1'b0));
		directed_rows.push_back(byte_row(8'h00, 1'b0));
		directed_rows.push_back(byte_row(8'h5A, 1'b1));
		// Two bytes held, then the unit is disabled: they leave unchanged with the next.
		directed_rows.push_back(byte_row(8'h11, 1'b0));
		directed_rows.push_back(byte_row(8'h22, 1'b0));
		directed_rows.push_back(write_row(CFG_ENABLE, 2'd0));
		directed_rows.push_back(byte_row(8'h33, 1'b1));
		// Three bytes held at 40k, then 24k: the fourth byte overruns, all go unchanged.
		directed_rows.push_back(write_row(CFG_ENABLE, 2'd1));
		directed_rows.push_back(byte_row(8'h01, 1'b0));
		directed_rows.push_back(byte_row(8'h02, 1'b0));
		directed_rows.push_back(byte_row(8'h03, 1'b0));
		directed_rows.push_back(write_row(CFG_RATE_MODE, RATE_24K));
		directed_rows.push_back(byte_row(8'h04, 1'b0));
		// Two bytes held at 40k, then 24k: the third completes a group and is converted.
		directed_rows.push_back(write_row(CFG_RATE_MODE, RATE_40K));
		directed_rows.push_back(byte_row(8'h10, 1'b0));
		directed_rows.push_back(byte_row(8'h20, 1'b0));
		directed_rows.push_back(write_row(CFG_RATE_MODE, RATE_24K));
		directed_rows.push_back(byte_row(8'h30, 1'b1));

		foreach (directed_rows[k]) begin
			if (directed_rows[k].kind == ROW_WRITE)
				write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_val);
			else
				send_byte(directed_rows[k]);
		end

		// Random phases. The first eight walk every rate and direction with repacking
		// on, the ninth runs disabled, later ones pick settings at random. Each phase is
		// mostly whole buffers of random bytes, some ending on a partial group, with a
		// little noise where the buffer end falls anywhere. A phase may end with a
		// partial group left open, which the next phase's settings then meet.
		p = 0;
		first = bytes_sent;
		while (bytes_sent - first < RANDOM_ITEMS) begin
			if (p < 8) begin
				on = 1'b1;
				rate = p[1:0];
				net = p[2];
			end else if (p == 8) begin
				on = 1'b0;
				rate = cfg_data_t'($urandom_range(0, 3));
				net = 1'($urandom_range(0, 1));
			end else begin
				on = ($urandom_range(0, 7) != 0);
				rate = cfg_data_t'($urandom_range(0, 3));
				net = 1'($urandom_range(0, 1));
			end
			write_reg(CFG_RATE_MODE, rate);
			write_reg(CFG_NET_DIR, {1'b0, net});
			write_reg(CFG_ENABLE, {1'b0, on});

			// Phase 3 (40k) sends without gaps while the receiver holds off, so the
			// queue fills and the input stalls; phase 5 simply runs at full rate.
			steady_send = (p == 3 || p == 5);
			if (p == 3)
				long_hold_req = 1'b1;

			if (!on)
				size = 1;
			else if (rate == RATE_24K)
				size = 3;
			else if (rate == RATE_40K)
				size = 5;
			else
				size = 1;

			target = bytes_sent + $urandom_range(24, 40);
			while (bytes_sent < target) begin
				pick = $urandom_range(0, 19);
				if (pick < 18) begin
					if (pick < 16)
						len = (size == 1) ? $urandom_range(1, 8) :
							size * $urandom_range(1, 4);
					else
						len = (size == 1) ? 1 :
							size * $urandom_range(0, 2) + $urandom_range(1, size - 1);
					for (int i = 0; i < len; i++)
						send_byte(byte_row(byte_t'($urandom), i == len - 1));
				end else begin
					len = $urandom_range(1, 6);
					for (int i = 0; i < len; i++)
						send_byte(byte_row(byte_t'($urandom), $urandom_range(0, 3) == 0));
				end
			end
			if (size > 1 && $urandom_range(0, 2) == 0) begin
				len = $urandom_range(1, size - 1);
				for (int i = 0; i < len; i++)
					send_byte(byte_row(byte_t'($urandom), 1'b0));
			end
			steady_send = 1'b0;
			p++;
		end

		drain_outputs();

		$display("Run covered %0d input bytes over the directed table and %0d random phases,",
			bytes_sent, p);
		$display("with %0d register writes and %0d output bytes checked.",
			reg_writes, bytes_checked);
		if (errors == 0)
			$display("g726_codeword_bit_order_convert_unit_tb: PASS");
		else
			$display("g726_codeword_bit_order_convert_unit_tb: FAIL");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/g726cbo_pkg.sv
rtl/core/g726cbo_if.sv
rtl/core/g726cbo_front.sv
rtl/core/g726cbo_queue.sv
rtl/core/g726cbo_back.sv
rtl/core/g726_codeword_bit_order_convert_unit.sv
rtl/core/g726cbo_checker.sv
tb/sv/g726_codeword_bit_order_convert_unit_tb.sv
